/* design/assert_macros.svh */
// Assertion macros used by the verification-only checker file of the accumulator.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define RSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("accumulator assertion failed");

// The consequent must hold at the edge after the antecedent.
`define RSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("accumulator assertion failed");

`endif

/* design/rsa_pkg.sv */
// Package for the regression sum accumulator: sizes, register codes and shared types.
// No dependencies; each other design .sv file refers to it by scoped names.
package rsa_pkg;

  localparam int CELLS     = 4096;
  localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CELL_W    = 12;
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_BITS = 8;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int SQ_W      = 63;
  localparam int XY_W      = 64;
  localparam int SUM_W     = 48;
  localparam int CNT_W     = 16;

  localparam int NUM_REGS  = 4;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int APB_AW    = REG_IDX_W + 2;
  localparam int APB_DW    = 32;

  // In time mode the x marker is fixed at -1.0 in Q8.8.
  localparam logic signed [SAMPLE_W-1:0] TIME_MARK = SAMPLE_W'(-(1 << FRAC_BITS));

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TIME_MODE  = 2'd0,
    REG_TIME_VALUE = 2'd1,
    REG_FILL_X     = 2'd2,
    REG_FILL_Y     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic                       time_mode;
    logic signed [SAMPLE_W-1:0] time_value;
    logic signed [SAMPLE_W-1:0] fill_x;
    logic signed [SAMPLE_W-1:0] fill_y;
  } rsa_cfg_t;

  typedef struct packed {
    logic        [SQ_W-1:0]  xx;
    logic        [SQ_W-1:0]  yy;
    logic signed [XY_W-1:0]  xy;
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
    logic        [CNT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

endpackage

/* design/rsa_cfg_regs.sv */
// APB register file for the accumulator: mode, time value and the two fill markers.
// Depends on rsa_pkg for the register codes and the configuration struct.
module rsa_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsa_pkg::APB_AW-1:0]    paddr,
  input  logic [rsa_pkg::APB_DW-1:0]    pwdata,
  output logic [rsa_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output rsa_pkg::rsa_cfg_t             cfg
);

  logic                                time_mode_r;
  logic signed [rsa_pkg::SAMPLE_W-1:0] time_value_r;
  logic signed [rsa_pkg::SAMPLE_W-1:0] fill_x_r;
  logic signed [rsa_pkg::SAMPLE_W-1:0] fill_y_r;
  logic                                wr_en;
  rsa_pkg::reg_idx_t                   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = rsa_pkg::reg_idx_t'(paddr[rsa_pkg::APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_mode_r  <= 1'b0;
      time_value_r <= '0;
      fill_x_r     <= '0;
      fill_y_r     <= '0;
    end else if (wr_en) begin
      case (idx)
        rsa_pkg::REG_TIME_MODE:  time_mode_r  <= pwdata[0];
        rsa_pkg::REG_TIME_VALUE: time_value_r <= pwdata[rsa_pkg::SAMPLE_W-1:0];
        rsa_pkg::REG_FILL_X:     fill_x_r     <= pwdata[rsa_pkg::SAMPLE_W-1:0];
        rsa_pkg::REG_FILL_Y:     fill_y_r     <= pwdata[rsa_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rsa_pkg::REG_TIME_MODE:  prdata = rsa_pkg::APB_DW'(time_mode_r);
      rsa_pkg::REG_TIME_VALUE: prdata = rsa_pkg::APB_DW'($unsigned(time_value_r));
      rsa_pkg::REG_FILL_X:     prdata = rsa_pkg::APB_DW'($unsigned(fill_x_r));
      rsa_pkg::REG_FILL_Y:     prdata = rsa_pkg::APB_DW'($unsigned(fill_y_r));
      default:                 prdata = '0;
    endcase
  end

  assign cfg.time_mode  = time_mode_r;
  assign cfg.time_value = time_value_r;
  assign cfg.fill_x     = fill_x_r;
  assign cfg.fill_y     = fill_y_r;

endmodule

/* design/rsa_store.sv */
// State memory of per-cell sums: one read and one write port, read data registered.
// Holds the clearing pass that zeroes every entry after reset. Depends on rsa_pkg.
module rsa_store (
  input  logic              clk,
  input  logic              rst_n,
  input  rsa_pkg::mem_req_t req,
  output rsa_pkg::entry_t   rd_data,
  output logic              clr_busy
);

  rsa_pkg::entry_t                mem [rsa_pkg::CELLS];
  rsa_pkg::entry_t                rd_data_r;
  logic [rsa_pkg::ADDR_W-1:0]     clr_addr_r;
  logic                           clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + rsa_pkg::ADDR_W'(1);
      if (clr_addr_r == rsa_pkg::ADDR_W'(rsa_pkg::CELLS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // The clearing pass owns the write port until it reaches the last entry.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

/* design/rsa_update.sv */
// Read-modify-write pipeline: sample select and marker check, products, saturating
// accumulate with write-back forwarding, and the result register. Depends on rsa_pkg.
module rsa_update (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rsa_pkg::rsa_cfg_t                   cfg,
  input  logic                                clr_busy,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [rsa_pkg::CELL_W-1:0]   in_cell_index,
  input  logic signed [rsa_pkg::SAMPLE_W-1:0] in_x_sample,
  input  logic signed [rsa_pkg::SAMPLE_W-1:0] in_y_sample,
  output rsa_pkg::mem_req_t                   mem_req,
  input  rsa_pkg::entry_t                     rd_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [rsa_pkg::CELL_W-1:0]   out_cell_out,
  output logic                                out_pair_used,
  output rsa_pkg::entry_t                     out_totals
);

  localparam int SW = rsa_pkg::SAMPLE_W;
  localparam int PW = rsa_pkg::PROD_W;

  function automatic logic signed [rsa_pkg::SUM_W-1:0] sat_add_sum(
    input logic signed [rsa_pkg::SUM_W-1:0] a,
    input logic signed [SW-1:0]             b
  );
    logic signed [rsa_pkg::SUM_W:0] s;
    s = (rsa_pkg::SUM_W+1)'(a) + (rsa_pkg::SUM_W+1)'(b);
    if (s[rsa_pkg::SUM_W] != s[rsa_pkg::SUM_W-1]) begin
      sat_add_sum = s[rsa_pkg::SUM_W] ? {1'b1, {(rsa_pkg::SUM_W-1){1'b0}}}
                                      : {1'b0, {(rsa_pkg::SUM_W-1){1'b1}}};
    end else begin
      sat_add_sum = s[rsa_pkg::SUM_W-1:0];
    end
  endfunction

  function automatic logic [rsa_pkg::SQ_W-1:0] sat_add_sq(
    input logic [rsa_pkg::SQ_W-1:0] a,
    input logic [PW-1:0]            b
  );
    logic [rsa_pkg::SQ_W:0] s;
    s = (rsa_pkg::SQ_W+1)'(a) + (rsa_pkg::SQ_W+1)'(b);
    sat_add_sq = s[rsa_pkg::SQ_W] ? {rsa_pkg::SQ_W{1'b1}} : s[rsa_pkg::SQ_W-1:0];
  endfunction

  // Handshake and stage control.
  logic out_free, s2_load, s1_load, accept, s2_wr, s1_move;

  // Request decode.
  logic signed [SW-1:0] x0, mark0;
  logic                 rng0, use0;

  // Stage 1: decoded request.
  logic                        s1_valid_r;
  logic [rsa_pkg::CELL_W-1:0]  s1_idx_r;
  logic signed [SW-1:0]        s1_x_r, s1_y_r;
  logic                        s1_use_r, s1_rng_r;
  logic signed [PW-1:0]        prod_xx, prod_yy, prod_xy;

  // Stage 2: products registered, memory data arriving.
  logic                        s2_valid_r;
  logic [rsa_pkg::CELL_W-1:0]  s2_idx_r;
  logic signed [SW-1:0]        s2_x_r, s2_y_r;
  logic                        s2_use_r, s2_rng_r;
  logic signed [PW-1:0]        s2_xx_r, s2_yy_r, s2_xy_r;
  logic                        fwd_r;
  rsa_pkg::entry_t             wb_r;
  rsa_pkg::entry_t             old_e, sum_e, new_e;
  logic signed [rsa_pkg::XY_W:0] xy_ext;

  // Result register.
  logic                        out_valid_r;
  logic [rsa_pkg::CELL_W-1:0]  out_idx_r;
  logic                        out_used_r;
  rsa_pkg::entry_t             out_tot_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s2_load  = !s2_valid_r || out_free;
  assign s1_load  = !s1_valid_r || s2_load;
  assign in_stall = clr_busy || !s1_load;
  assign accept   = in_valid && !in_stall;
  assign s2_wr    = s2_valid_r && out_free && s2_rng_r;
  assign s1_move  = s1_valid_r && s2_load;

  always_comb begin
    x0    = cfg.time_mode ? cfg.time_value : in_x_sample;
    mark0 = cfg.time_mode ? rsa_pkg::TIME_MARK : cfg.fill_x;
    rng0  = (32'(in_cell_index) < 32'(rsa_pkg::CELLS));
    use0  = rng0 && (x0 != mark0) && (in_y_sample != cfg.fill_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && accept) begin
      s1_idx_r <= in_cell_index;
      s1_x_r   <= x0;
      s1_y_r   <= in_y_sample;
      s1_use_r <= use0;
      s1_rng_r <= rng0;
    end
  end

  // Squares are never negative, so the signed product doubles as the magnitude square.
  assign prod_xx = PW'(s1_x_r) * PW'(s1_x_r);
  assign prod_yy = PW'(s1_y_r) * PW'(s1_y_r);
  assign prod_xy = PW'(s1_x_r) * PW'(s1_y_r);

  assign mem_req.rd_en   = s1_move;
  assign mem_req.rd_addr = rsa_pkg::ADDR_W'(s1_idx_r);
  assign mem_req.wr_en   = s2_wr;
  assign mem_req.wr_addr = rsa_pkg::ADDR_W'(s2_idx_r);
  assign mem_req.wr_data = new_e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= s1_valid_r;
      // The memory read of the entering request happens at the same edge as this write,
      // so it would return the old entry.
      fwd_r      <= s2_wr && s1_valid_r && (s1_idx_r == s2_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_idx_r <= s1_idx_r;
      s2_x_r   <= s1_x_r;
      s2_y_r   <= s1_y_r;
      s2_use_r <= s1_use_r;
      s2_rng_r <= s1_rng_r;
      s2_xx_r  <= prod_xx;
      s2_yy_r  <= prod_yy;
      s2_xy_r  <= prod_xy;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_wr) begin
      wb_r <= new_e;
    end
  end

  always_comb begin
    old_e  = fwd_r ? wb_r : rd_data;
    xy_ext = (rsa_pkg::XY_W+1)'($signed(old_e.xy)) + (rsa_pkg::XY_W+1)'(s2_xy_r);
    sum_e.xx = sat_add_sq(old_e.xx, $unsigned(s2_xx_r));
    sum_e.yy = sat_add_sq(old_e.yy, $unsigned(s2_yy_r));
    if (xy_ext[rsa_pkg::XY_W] != xy_ext[rsa_pkg::XY_W-1]) begin
      sum_e.xy = xy_ext[rsa_pkg::XY_W] ? {1'b1, {(rsa_pkg::XY_W-1){1'b0}}}
                                       : {1'b0, {(rsa_pkg::XY_W-1){1'b1}}};
    end else begin
      sum_e.xy = xy_ext[rsa_pkg::XY_W-1:0];
    end
    sum_e.x   = sat_add_sum($signed(old_e.x), s2_x_r);
    sum_e.y   = sat_add_sum($signed(old_e.y), s2_y_r);
    sum_e.cnt = (old_e.cnt == {rsa_pkg::CNT_W{1'b1}}) ? old_e.cnt
                                                      : old_e.cnt + rsa_pkg::CNT_W'(1);
    new_e = s2_use_r ? sum_e : old_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid_r) begin
      out_idx_r  <= s2_idx_r;
      out_used_r <= s2_use_r;
      out_tot_r  <= s2_rng_r ? new_e : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cell_out  = out_idx_r;
  assign out_pair_used = out_used_r;
  assign out_totals    = out_tot_r;

endmodule

/* design/regression_sum_accumulator.sv */
// Channel  Side    Handshake            Payload
// in       input   in_valid / in_stall   cell_index, x_sample, y_sample
// out      output  out_valid / out_stall cell_out, pair_used, six totals
// cfg      APB     psel/penable/pready   time_mode, time_value, fill_x, fill_y
//
// One request per cycle is taken while results are taken; the single write port of the
// state memory sets that rate, and a same-cell request right behind another is served
// from the write-back register. Requests pass stages 1 and 2 and the result register.
// After reset a clearing pass zeroes the 4096 entries, one per cycle; in_stall is high
// for the whole pass while configuration writes are taken as usual. After it, in_stall
// rises only once all stages are full and stalled. A stalled result holds its value.
module regression_sum_accumulator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic        [rsa_pkg::APB_AW-1:0]   paddr,
  input  logic        [rsa_pkg::APB_DW-1:0]   pwdata,
  output logic        [rsa_pkg::APB_DW-1:0]   prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [rsa_pkg::CELL_W-1:0]   in_cell_index,
  input  logic signed [rsa_pkg::SAMPLE_W-1:0] in_x_sample,
  input  logic signed [rsa_pkg::SAMPLE_W-1:0] in_y_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic        [rsa_pkg::CELL_W-1:0]   out_cell_out,
  output logic                                out_pair_used,
  output logic        [rsa_pkg::SQ_W-1:0]     out_total_xx,
  output logic        [rsa_pkg::SQ_W-1:0]     out_total_yy,
  output logic signed [rsa_pkg::XY_W-1:0]     out_total_xy,
  output logic signed [rsa_pkg::SUM_W-1:0]    out_total_x,
  output logic signed [rsa_pkg::SUM_W-1:0]    out_total_y,
  output logic        [rsa_pkg::CNT_W-1:0]    out_sample_count
);

  rsa_pkg::rsa_cfg_t cfg;
  rsa_pkg::mem_req_t mem_req;
  rsa_pkg::entry_t   rd_data;
  rsa_pkg::entry_t   totals;
  logic              clr_busy;

  rsa_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rsa_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rd_data  (rd_data),
    .clr_busy (clr_busy)
  );

  rsa_update u_update (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .clr_busy      (clr_busy),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cell_index (in_cell_index),
    .in_x_sample   (in_x_sample),
    .in_y_sample   (in_y_sample),
    .mem_req       (mem_req),
    .rd_data       (rd_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_cell_out  (out_cell_out),
    .out_pair_used (out_pair_used),
    .out_totals    (totals)
  );

  assign out_total_xx     = totals.xx;
  assign out_total_yy     = totals.yy;
  assign out_total_xy     = totals.xy;
  assign out_total_x      = totals.x;
  assign out_total_y      = totals.y;
  assign out_sample_count = totals.cnt;

endmodule

/* design/rsa_checker.sv */
// Port-level checks for the accumulator, attached to the top level by a bind.
// Depends on rsa_pkg for widths and on assert_macros.svh for the assertion forms.
`include "assert_macros.svh"

module rsa_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic        [rsa_pkg::CELL_W-1:0]   out_cell_out,
  input logic                                out_pair_used,
  input logic        [rsa_pkg::SQ_W-1:0]     out_total_xx,
  input logic signed [rsa_pkg::XY_W-1:0]     out_total_xy,
  input logic signed [rsa_pkg::SUM_W-1:0]    out_total_x,
  input logic signed [rsa_pkg::SUM_W-1:0]    out_total_y,
  input logic        [rsa_pkg::CNT_W-1:0]    out_sample_count
);

  // A stalled result stays on the port with its cell and xy total unchanged.
  `RSA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_cell_out) && $stable(out_total_xy))

  // A pair that was added always leaves a nonzero count behind.
  `RSA_ASSERT_IMP(a_used_count, clk, rst_n, out_valid && out_pair_used, out_sample_count != '0)

  // A cell that never took a pair reports empty xx, x and y sums.
  `RSA_ASSERT_IMP(a_empty_sums, clk, rst_n, out_valid && (out_sample_count == '0), (out_total_xx == '0) && (out_total_x == '0) && (out_total_y == '0))

  // The clearing pass holds off requests right after reset.
  `RSA_ASSERT_IMP(a_clear_stall, clk, rst_n, !$past(rst_n), in_stall)

endmodule

bind regression_sum_accumulator rsa_checker u_rsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_cell_out     (out_cell_out),
  .out_pair_used    (out_pair_used),
  .out_total_xx     (out_total_xx),
  .out_total_xy     (out_total_xy),
  .out_total_x      (out_total_x),
  .out_total_y      (out_total_y),
  .out_sample_count (out_sample_count)
);

/* test/tb_regression_sum_accumulator.sv */
// Testbench for regression_sum_accumulator: directed rows, then random requests under
// changing idle patterns and settings, checked against a per-cell sum predictor.
// Depends on rsa_pkg and the accumulator RTL only.
`timescale 1ns / 1ps

module tb_regression_sum_accumulator;
  import rsa_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 4;
  localparam int QUEUE_DEPTH = 8;
  localparam logic signed [SAMPLE_W-1:0] TIME_X_MARK = 16'hFF00;
  localparam logic [63:0] SQ_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint XY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint XY_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;
  localparam longint SUM_MAX = 64'sd140737488355327;
  localparam longint SUM_MIN = -64'sd140737488355328;

  typedef struct packed {
    logic        [CELL_W-1:0] cell_idx;
    logic                     used;
    logic        [SQ_W-1:0]   xx;
    logic        [SQ_W-1:0]   yy;
    logic signed [XY_W-1:0]   xy;
    logic signed [SUM_W-1:0]  x;
    logic signed [SUM_W-1:0]  y;
    logic        [CNT_W-1:0]  cnt;
  } cell_totals_t;

  typedef struct packed {
    logic        [CELL_W-1:0]   cell_idx;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic                       known;
    cell_totals_t               totals;
  } pair_req_t;

  typedef enum logic {ROW_PAIR, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    reg_sel;
    logic [31:0] wdata;
    pair_req_t   req;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CELL_W-1:0] in_cell_index = '0;
  logic signed [SAMPLE_W-1:0] in_x_sample = '0;
  logic signed [SAMPLE_W-1:0] in_y_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CELL_W-1:0] out_cell_out;
  logic out_pair_used;
  logic [SQ_W-1:0] out_total_xx;
  logic [SQ_W-1:0] out_total_yy;
  logic signed [XY_W-1:0] out_total_xy;
  logic signed [SUM_W-1:0] out_total_x;
  logic signed [SUM_W-1:0] out_total_y;
  logic [CNT_W-1:0] out_sample_count;

  regression_sum_accumulator dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_cell_index(in_cell_index),
    .in_x_sample(in_x_sample), .in_y_sample(in_y_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_cell_out(out_cell_out),
    .out_pair_used(out_pair_used), .out_total_xx(out_total_xx),
    .out_total_yy(out_total_yy), .out_total_xy(out_total_xy),
    .out_total_x(out_total_x), .out_total_y(out_total_y),
    .out_sample_count(out_sample_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted contents of the accumulator and its registers.
  logic        [SQ_W-1:0]  xx_sum [CELLS];
  logic        [SQ_W-1:0]  yy_sum [CELLS];
  logic signed [XY_W-1:0]  xy_sum [CELLS];
  logic signed [SUM_W-1:0] x_sum [CELLS];
  logic signed [SUM_W-1:0] y_sum [CELLS];
  logic        [CNT_W-1:0] pair_count [CELLS];
  logic use_time_x = 1'b0;
  logic signed [SAMPLE_W-1:0] time_x = '0;
  logic signed [SAMPLE_W-1:0] marker_x = '0;
  logic signed [SAMPLE_W-1:0] marker_y = '0;

  pair_req_t pending_pairs[$];
  cell_totals_t expected_totals[$];
  pair_req_t offered_req = '0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_request = 0;
  int error_count = 0;
  int cycle_count = 0;

  dir_row_t directed_rows [33] = '{
    // Right after reset both markers are zero.
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd5, 16'h0100, 16'h0200, 1'b1,
      '{12'd5, 1'b1, 63'd65536, 63'd262144, 64'sd131072, 48'sd256, 48'sd512, 16'd1}}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd7, 16'h0000, 16'h0064, 1'b1,
      '{12'd7, 1'b0, 63'd0, 63'd0, 64'sd0, 48'sd0, 48'sd0, 16'd0}}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd5, 16'h0300, 16'h0000, 1'b1,
      '{12'd5, 1'b0, 63'd65536, 63'd262144, 64'sd131072, 48'sd256, 48'sd512, 16'd1}}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd4095, 16'h8000, 16'h8000, 1'b1,
      '{12'd4095, 1'b1, 63'd1073741824, 63'd1073741824, 64'sd1073741824,
        -48'sd32768, -48'sd32768, 16'd1}}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd4094, 16'h7FFF, 16'h8000, 1'b1,
      '{12'd4094, 1'b1, 63'd1073676289, 63'd1073741824, -64'sd1073709056,
        48'sd32767, -48'sd32768, 16'd1}}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd4094, 16'h7FFF, 16'h8000, 1'b1,
      '{12'd4094, 1'b1, 63'd2147352578, 63'd2147483648, -64'sd2147418112,
        48'sd65534, -48'sd65536, 16'd2}}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd0, 16'hFFFF, 16'h7FFF, 1'b0, '0}},
    '{ROW_CFG, REG_FILL_X, 32'hABCD_1234, '0},
    '{ROW_CFG, REG_FILL_Y, 32'h0000_FFFF, '0},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd0, 16'h1234, 16'h0010, 1'b0, '0}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd0, 16'h0010, 16'hFFFF, 1'b0, '0}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd0, 16'h0000, 16'h0000, 1'b0, '0}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'h800, 16'h1233, 16'hFFFE, 1'b0, '0}},
    // Time mode: x comes from the register and the x marker is fixed at -1.0.
    '{ROW_CFG, REG_TIME_VALUE, 32'h5A5A_0A00, '0},
    '{ROW_CFG, REG_TIME_MODE, 32'hFFFF_FFFF, '0},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd3, 16'h1234, 16'h0100, 1'b0, '0}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd3, 16'hBEEF, 16'hFFFF, 1'b0, '0}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd3, 16'hFF00, 16'h0020, 1'b0, '0}},
    '{ROW_CFG, REG_TIME_VALUE, 32'h0000_FF00, '0},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd3, 16'h0100, 16'h0100, 1'b0, '0}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd3, 16'hFF00, 16'h7FFF, 1'b0, '0}},
    '{ROW_CFG, REG_TIME_VALUE, 32'h0000_8000, '0},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'hFFF, 16'h0000, 16'h7FFF, 1'b0, '0}},
    '{ROW_CFG, REG_TIME_VALUE, 32'hFFFF_7FFF, '0},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'hFFF, 16'h0000, 16'h8000, 1'b0, '0}},
    '{ROW_CFG, REG_TIME_MODE, 32'h0000_0000, '0},
    '{ROW_CFG, REG_FILL_X, 32'h0000_8000, '0},
    '{ROW_CFG, REG_FILL_Y, 32'h0000_7FFF, '0},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd1, 16'h8000, 16'h0001, 1'b0, '0}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd1, 16'h0001, 16'h7FFF, 1'b0, '0}},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd1, 16'h7FFF, 16'h8000, 1'b0, '0}},
    // Only bit 0 of the mode register counts, so this keeps variable mode.
    '{ROW_CFG, REG_TIME_MODE, 32'hFFFF_FFFE, '0},
    '{ROW_PAIR, REG_TIME_MODE, 32'h0, '{12'd1, 16'hFF00, 16'hFF00, 1'b0, '0}}
  };

  function automatic cell_totals_t accumulate_pair(pair_req_t r);
    cell_totals_t t;
    longint xv, yv, xmark, prod, s;
    logic [63:0] u;
    logic use_pair;
    yv = $signed(r.y);
    if (use_time_x) begin
      xv = $signed(time_x);
      xmark = $signed(TIME_X_MARK);
    end else begin
      xv = $signed(r.x);
      xmark = $signed(marker_x);
    end
    use_pair = (xv != xmark) && (yv != $signed(marker_y));
    if (use_pair) begin
      u = {1'b0, xx_sum[r.cell_idx]} + 64'(xv * xv);
      xx_sum[r.cell_idx] = (u > SQ_MAX) ? SQ_MAX[SQ_W-1:0] : u[SQ_W-1:0];
      u = {1'b0, yy_sum[r.cell_idx]} + 64'(yv * yv);
      yy_sum[r.cell_idx] = (u > SQ_MAX) ? SQ_MAX[SQ_W-1:0] : u[SQ_W-1:0];
      prod = xv * yv;
      s = xy_sum[r.cell_idx];
      if (prod > 0 && s > XY_MAX - prod) s = XY_MAX;
      else if (prod < 0 && s < XY_MIN - prod) s = XY_MIN;
      else s = s + prod;
      xy_sum[r.cell_idx] = s;
      s = longint'(x_sum[r.cell_idx]) + xv;
      x_sum[r.cell_idx] = SUM_W'((s > SUM_MAX) ? SUM_MAX : ((s < SUM_MIN) ? SUM_MIN : s));
      s = longint'(y_sum[r.cell_idx]) + yv;
      y_sum[r.cell_idx] = SUM_W'((s > SUM_MAX) ? SUM_MAX : ((s < SUM_MIN) ? SUM_MIN : s));
      if (pair_count[r.cell_idx] != '1)
        pair_count[r.cell_idx] = pair_count[r.cell_idx] + 1'b1;
    end
    t.cell_idx = r.cell_idx;
    t.used = use_pair;
    t.xx = xx_sum[r.cell_idx];
    t.yy = yy_sum[r.cell_idx];
    t.xy = xy_sum[r.cell_idx];
    t.x = x_sum[r.cell_idx];
    t.y = y_sum[r.cell_idx];
    t.cnt = pair_count[r.cell_idx];
    return t;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Sender: offers queued requests, holding each one while the block stalls it.
  always @(posedge clk) begin : sender
    pair_req_t next_req;
    if (rst_n && in_valid && !in_stall) begin
      if (offered_req.known) begin
        void'(accumulate_pair(offered_req));
        expected_totals.push_back(offered_req.totals);
      end else begin
        expected_totals.push_back(accumulate_pair(offered_req));
      end
    end
    if (in_valid && in_stall) begin
      // The stalled request keeps its payload.
    end else if (rst_n && pending_pairs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
      next_req = pending_pairs.pop_front();
      offered_req <= next_req;
      in_valid <= 1'b1;
      in_cell_index <= next_req.cell_idx;
      in_x_sample <= next_req.x;
      in_y_sample <= next_req.y;
    end else begin
      in_valid <= 1'b0;
      in_cell_index <= CELL_W'($urandom);
      in_x_sample <= SAMPLE_W'($urandom);
      in_y_sample <= SAMPLE_W'($urandom);
    end
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  always @(posedge clk) begin : receiver
    int hold_left;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    cell_totals_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_totals.size() == 0) begin
        error_count++;
        $error("result for cell %0h with no request waiting", out_cell_out);
      end else begin
        want = expected_totals.pop_front();
        check_field("cell_out", 64'(want.cell_idx), 64'(out_cell_out));
        check_field("pair_used", 64'(want.used), 64'(out_pair_used));
        check_field("total_xx", 64'(want.xx), 64'(out_total_xx));
        check_field("total_yy", 64'(want.yy), 64'(out_total_yy));
        check_field("total_xy", 64'(want.xy), 64'(out_total_xy));
        check_field("total_x", 64'(want.x), 64'(out_total_x));
        check_field("total_y", 64'(want.y), 64'(out_total_y));
        check_field("sample_count", 64'(want.cnt), 64'(out_sample_count));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("regression_sum_accumulator test failed");
      $finish;
    end
  end

  task automatic write_register(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TIME_MODE:  use_time_x = value[0];
      REG_TIME_VALUE: time_x = value[SAMPLE_W-1:0];
      REG_FILL_X:     marker_x = value[SAMPLE_W-1:0];
      REG_FILL_Y:     marker_y = value[SAMPLE_W-1:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pwdata <= $urandom;
    @(posedge clk);
  endtask

  task automatic queue_pair(pair_req_t r);
    while (pending_pairs.size() >= QUEUE_DEPTH) @(posedge clk);
    pending_pairs.push_back(r);
  endtask

  // Waits until every queued request has been answered and the pipeline is empty.
  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_valid || expected_totals.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One stretch of random requests under a fresh random setting of all registers.
  task automatic run_segment(int n_pairs, int hold_cycles);
    logic [CELL_W-1:0] hot [6];
    logic [CELL_W-1:0] prev_cell;
    pair_req_t r;
    wait_drained();
    write_register(REG_TIME_MODE, $urandom);
    write_register(REG_TIME_VALUE, {16'($urandom), pick_sample()});
    write_register(REG_FILL_X, {16'($urandom), pick_sample()});
    write_register(REG_FILL_Y, {16'($urandom), pick_sample()});
    foreach (hot[i]) hot[i] = CELL_W'($urandom);
    prev_cell = hot[0];
    if (hold_cycles > 0) hold_request = hold_cycles;
    repeat (n_pairs) begin
      r = '0;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: r.cell_idx = hot[$urandom_range(5)];
        5, 6:          r.cell_idx = prev_cell;
        default:       r.cell_idx = CELL_W'($urandom);
      endcase
      case ($urandom_range(9))
        0:       r.x = marker_x;
        1:       r.x = TIME_X_MARK;
        default: r.x = pick_sample();
      endcase
      r.y = ($urandom_range(9) == 0) ? marker_y : pick_sample();
      queue_pair(r);
      prev_cell = r.cell_idx;
    end
  endtask

  initial begin : stimulus
    for (int c = 0; c < CELLS; c++) begin
      xx_sum[c] = '0;
      yy_sum[c] = '0;
      xy_sum[c] = '0;
      x_sum[c] = '0;
      y_sum[c] = '0;
      pair_count[c] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 18;
    rx_idle_pct = 64;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_register(directed_rows[i].reg_sel, directed_rows[i].wdata);
      end else begin
        queue_pair(directed_rows[i].req);
      end
    end

    run_segment(150, 0);
    // The receiver holds off long enough for the block to fill and stall its input.
    run_segment(150, 400);
    run_segment(150, 0);
    run_segment(150, 0);

    wait_drained();
    tx_idle_pct = 64;
    rx_idle_pct = 18;
    repeat (4) run_segment(150, 0);

    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (4) run_segment(160, 0);

    wait_drained();
    if (error_count == 0) begin
      $display("regression_sum_accumulator test passed");
    end else begin
      $display("regression_sum_accumulator test failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/rsa_pkg.sv
design/rsa_cfg_regs.sv
design/rsa_store.sv
design/rsa_update.sv
design/regression_sum_accumulator.sv
design/rsa_checker.sv
test/tb_regression_sum_accumulator.sv
